@@ rtl/lmsr_pkg.sv @@
// Shared types and constants for the scrolling LED matrix column source.
// Used by every module of the block; depends on nothing else.
package lmsr_pkg;

  // Default pattern store depth in column bytes.
  localparam int unsigned PATTERN_DEPTH_DEF = 64;

  // Depth of the command queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_SPEED   = 2'd1;

  // Register reset values.
  localparam logic [6:0] PATTERN_LENGTH_RST = 7'd8;
  localparam logic [7:0] SCROLL_SPEED_RST   = 8'd0;

  // Input action codes.
  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_REFRESH = 1'b1;

  // Speeds at or above this value flip a whole page per advance.
  localparam logic [7:0] SPEED_PAGE = 8'd50;
  localparam int unsigned STEP_PAGE = 8;

  // Column number that closes a refresh.
  localparam logic [2:0] LAST_COL = 3'd7;

  // Input word.
  typedef struct packed {
    logic       action;
    logic [5:0] load_index;
    logic [7:0] load_data;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [2:0] column_index;
    logic [7:0] column_data;
    logic       last;
  } result_t;

  // Classified command held in the queue.
  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] index;
    logic [7:0] data;
  } cmd_t;

  // Configuration register contents seen by the back end.
  typedef struct packed {
    logic [6:0] pattern_length;
    logic [7:0] scroll_speed;
  } cfg_t;

endpackage

@@ rtl/led_matrix_scroll_refresh.sv @@
// Scrolling 8x8 LED matrix column source. A load word is written to the store when the back
// end pops it; a refresh word first runs the offset modulo unit, then for each column a store
// read (S_RD) and a result register step (S_OUT), giving 8 results per refresh. The single
// store read port sets the column pace.
// Synchronous reset clears control, offset, frame count and configuration registers; the store is not cleared.
// The receiver cannot stall: each result is shown for one cycle with result_strobe.
module led_matrix_scroll_refresh
  import lmsr_pkg::*;
#(
  parameter int unsigned PATTERN_DEPTH = PATTERN_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item,
  output result_t              result,
  output logic                 result_strobe,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  cfg_t cfg;
  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  // Configuration registers accept a word every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_length <= PATTERN_LENGTH_RST;
      cfg.scroll_speed   <= SCROLL_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: cfg.pattern_length <= cfg_data[6:0];
        CFG_SCROLL_SPEED:   cfg.scroll_speed   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end.
  lmsr_front #(
    .DEPTH (PATTERN_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .busy     (busy),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Command queue.
  lmsr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end.
  lmsr_back #(
    .DEPTH (PATTERN_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule

@@ rtl/lmsr_front.sv @@
// Front end: accepts input words, classifies them and drops loads outside the store.
// Depends on lmsr_pkg.
module lmsr_front
  import lmsr_pkg::*;
#(
  parameter int unsigned DEPTH = PATTERN_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  item_t item,
  output logic  busy,
  input  logic  q_full,
  output logic  push,
  output cmd_t  push_cmd
);

  logic       stage_valid;
  cmd_t       stage_cmd;
  logic       accept;
  logic       keep;
  logic [8:0] idx_w;

  // Handshake: the stage holds one word until the queue takes it.
  assign push   = stage_valid && !q_full;
  assign busy   = stage_valid && q_full;
  assign accept = start && !busy;

  // A refresh is always kept; a load only when it addresses the store.
  assign idx_w = {3'b000, item.load_index};
  assign keep  = (item.action == ACT_REFRESH) || (idx_w < 9'(DEPTH));

  // Stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= (accept && keep) || (stage_valid && !push);
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      stage_cmd.op    <= (item.action == ACT_REFRESH) ? OP_REFRESH : OP_LOAD;
      stage_cmd.index <= item.load_index;
      stage_cmd.data  <= item.load_data;
    end
  end

  assign push_cmd = stage_cmd;

endmodule

@@ rtl/lmsr_queue.sv @@
// Short in-order command queue between the front and back ends.
// Depends on lmsr_pkg.
module lmsr_queue
  import lmsr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full       = (count == NW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + NW'(1))
    else $error("fill count did not follow a write");
`endif

endmodule

@@ rtl/lmsr_back.sv @@
// Back end: pattern store, offset modulo unit, column read-out and scroll update.
// Depends on lmsr_pkg.
module lmsr_back
  import lmsr_pkg::*;
#(
  parameter int unsigned DEPTH = PATTERN_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    head_valid,
  input  cmd_t    head,
  output logic    pop,
  output result_t result,
  output logic    result_strobe
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned CNT_W = $clog2(AW);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_RD   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t           state;
  logic [7:0]       mem [DEPTH];
  logic [AW-1:0]    offset;
  logic [7:0]       frame_counter;
  logic [CW-1:0]    len_r;
  logic [7:0]       speed_r;
  logic [AW-1:0]    div_r;
  logic [CW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    addr;
  logic [2:0]       col;
  logic [7:0]       rdata;

  logic [8:0]       plen_w;
  logic [8:0]       eff_w;
  logic [CW-1:0]    eff_len;
  logic [8:0]       idx_w;
  logic [AW-1:0]    waddr;
  logic             do_load;
  logic             do_refresh;
  logic [CW-1:0]    rem_shift;
  logic [CW-1:0]    rem_next;
  logic [CW-1:0]    addr_inc;
  logic [AW-1:0]    addr_next;
  logic [CW-1:0]    step_w;
  logic [7:0]       fc_inc;
  logic             adv;
  logic [CW-1:0]    off_sum;
  logic [AW-1:0]    off_next;

  // Command pop and decode.
  assign pop        = (state == S_IDLE) && head_valid;
  assign do_load    = pop && (head.op == OP_LOAD);
  assign do_refresh = pop && (head.op == OP_REFRESH);
  assign idx_w      = {3'b000, head.index};
  assign waddr      = idx_w[AW-1:0];

  // Effective length: zero reads as one, anything above the store as its depth.
  always_comb begin
    plen_w = {2'b00, cfg.pattern_length};
    if (plen_w == 9'd0) begin
      eff_w = 9'd1;
    end else if (plen_w > 9'(DEPTH)) begin
      eff_w = 9'(DEPTH);
    end else begin
      eff_w = plen_w;
    end
  end
  assign eff_len = eff_w[CW-1:0];

  // One restoring step of offset modulo length.
  assign rem_shift = {rem[CW-2:0], div_r[AW-1]};
  assign rem_next  = (rem_shift >= len_r) ? rem_shift - len_r : rem_shift;

  // Next column address wraps at the pattern length.
  assign addr_inc  = {1'b0, addr} + CW'(1);
  assign addr_next = (addr_inc == len_r) ? '0 : addr_inc[AW-1:0];

  // Scroll step chosen by speed.
  always_comb begin
    if (speed_r >= SPEED_PAGE) begin
      step_w = CW'(STEP_PAGE);
    end else if (speed_r == 8'd0) begin
      step_w = '0;
    end else begin
      step_w = CW'(1);
    end
  end

  // Frame count and offset advance at the end of a refresh.
  assign fc_inc   = frame_counter + 8'd1;
  assign adv      = (fc_inc >= speed_r);
  assign off_sum  = {1'b0, offset} + step_w;
  assign off_next = (off_sum >= len_r) ? '0 : off_sum[AW-1:0];

  // Pattern store write and registered read.
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[waddr] <= head.data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RD) begin
      rdata <= mem[addr];
    end
  end

  // Sequencer, scroll state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      offset        <= '0;
      frame_counter <= 8'd0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (do_refresh) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (cnt == '0) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_OUT;
        end
        S_OUT: begin
          result_strobe <= 1'b1;
          if (col == LAST_COL) begin
            state         <= S_IDLE;
            frame_counter <= adv ? 8'd0 : fc_inc;
            if (adv) begin
              offset <= off_next;
            end
          end else begin
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working registers and the result word.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (do_refresh) begin
          len_r   <= eff_len;
          speed_r <= cfg.scroll_speed;
          div_r   <= offset;
          rem     <= '0;
          cnt     <= CNT_W'(AW - 1);
          col     <= 3'd0;
        end
      end
      S_MOD: begin
        rem   <= rem_next;
        div_r <= {div_r[AW-2:0], 1'b0};
        cnt   <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          addr <= rem_next[AW-1:0];
        end
      end
      S_OUT: begin
        result.column_index <= col;
        result.column_data  <= rdata;
        result.last         <= (col == LAST_COL);
        col                 <= col + 3'd1;
        addr                <= addr_next;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for two cycles");

  a_rem_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOD) |-> (rem < len_r))
    else $error("modulo remainder not below the length");

  a_last_ends_refresh: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |-> (state == S_IDLE))
    else $error("last column shown while the refresh is still running");
`endif

endmodule

@@ sim/lmsr_frame_monitor.sv @@
// Watches the scrolling LED matrix column source, predicts each refresh and checks every column.
// Depends on lmsr_pkg for the item, result and register index types.
module lmsr_frame_monitor
  import lmsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  item_t                item,
  input  result_t              result,
  input  logic                 result_strobe,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output int                   fail_count,
  output int                   pending
);

  // Predicted copy of the pattern store, scroll position and registers.
  logic [7:0] store_bytes [64];
  logic [5:0] offset;
  logic [7:0] frames;
  logic [6:0] length_reg;
  logic [7:0] speed_reg;

  // Columns predicted but not yet seen, oldest first.
  result_t expected_columns [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // A length of zero shows one column; anything above the store depth is clamped.
  function automatic int usable_length(input logic [6:0] len);
    if (len == 7'd0) return 1;
    if (len > 7'd64) return 64;
    return int'(len);
  endfunction

  // Predicts the eight columns of one refresh, then steps the frame count and offset.
  task automatic scan_frame();
    int         span;
    int         addr;
    int         stride;
    logic [6:0] advanced;
    result_t    col;
    span = usable_length(length_reg);
    for (int c = 0; c < 8; c++) begin
      addr = (int'(offset) + c) % span;
      col.column_index = 3'(c);
      col.column_data  = store_bytes[addr];
      col.last         = (3'(c) == LAST_COL);
      expected_columns.push_back(col);
    end
    if (speed_reg >= SPEED_PAGE) begin
      stride = STEP_PAGE;
    end else if (speed_reg == 8'd0) begin
      stride = 0;
    end else begin
      stride = 1;
    end
    frames = frames + 8'd1;
    if (frames >= speed_reg) begin
      frames   = 8'd0;
      advanced = {1'b0, offset} + 7'(stride);
      offset   = (int'(advanced) >= span) ? 6'd0 : advanced[5:0];
    end
  endtask

  // Register writes, column checks and new words, all sampled at the rising edge.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      offset     = 6'd0;
      frames     = 8'd0;
      length_reg = PATTERN_LENGTH_RST;
      speed_reg  = SCROLL_SPEED_RST;
      expected_columns.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PATTERN_LENGTH: length_reg = cfg_data[6:0];
          CFG_SCROLL_SPEED:   speed_reg  = cfg_data;
          default: ;
        endcase
      end
      if (result_strobe) begin
        if (expected_columns.size() == 0) begin
          $error("column word with nothing expected: index %0d data %02h last %0b",
                 result.column_index, result.column_data, result.last);
          fail_count++;
        end else begin
          want = expected_columns.pop_front();
          if (result.column_index !== want.column_index) begin
            $error("column_index expected %0d got %0d", want.column_index, result.column_index);
            fail_count++;
          end
          if (result.column_data !== want.column_data) begin
            $error("column_data expected %02h got %02h", want.column_data, result.column_data);
            fail_count++;
          end
          if (result.last !== want.last) begin
            $error("last expected %0b got %0b", want.last, result.last);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (item.action == ACT_REFRESH) begin
          scan_frame();
        end else begin
          store_bytes[item.load_index] = item.load_data;
        end
      end
    end
    pending <= expected_columns.size();
  end

endmodule

@@ sim/tb_top.sv @@
// Top of the scrolling LED matrix column source testbench: clock, reset, stimulus and verdict.
// Depends on lmsr_pkg, led_matrix_scroll_refresh and lmsr_frame_monitor.
module tb_top;
  import lmsr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  item_t                item      = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_PATTERN_LENGTH;
  logic [7:0]           cfg_data  = 8'd0;
  logic                 busy;
  result_t              result;
  logic                 result_strobe;
  logic                 cfg_ready;
  int                   fail_count;
  int                   pending;

  // Stimulus bookkeeping: which store bytes hold data and how many columns are in use.
  bit written_cols [64];
  int span_now  = 8;
  int gap_pct   = 0;
  int cycle_count = 0;

  always #10 clk = ~clk;

  led_matrix_scroll_refresh u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result        (result),
    .result_strobe (result_strobe),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lmsr_frame_monitor u_monitor (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result        (result),
    .result_strobe (result_strobe),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("led_matrix_scroll_refresh verification failed");
      $finish;
    end
  end

  // Offers one word after a random idle gap and holds it until the block takes it.
  task automatic send_word(input item_t w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_byte(input logic [5:0] idx, input logic [7:0] val);
    written_cols[idx] = 1'b1;
    send_word(item_t'{action: ACT_LOAD, load_index: idx, load_data: val});
  endtask

  // Fills any column in use that was never loaded, so that no refresh reads an empty entry.
  task automatic refresh_frame();
    for (int a = 0; a < span_now; a++) begin
      if (!written_cols[a]) load_byte(6'(a), 8'($urandom_range(255)));
    end
    send_word(item_t'{action: ACT_REFRESH, load_index: 6'($urandom_range(63)),
                      load_data: 8'($urandom_range(255))});
  endtask

  // Stops sending and waits until every predicted column has come out and the block is quiet.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PATTERN_LENGTH) begin
      if (val[6:0] == 7'd0) begin
        span_now = 1;
      end else if (val[6:0] > 7'd64) begin
        span_now = 64;
      end else begin
        span_now = int'(val[6:0]);
      end
    end
  endtask

  task automatic configure(input logic [7:0] len, input logic [7:0] speed);
    settle();
    write_reg(CFG_PATTERN_LENGTH, len);
    write_reg(CFG_SCROLL_SPEED, speed);
  endtask

  initial begin
    logic [7:0] len_pick;
    logic [7:0] speed_pick;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme bytes with the reset settings, a static picture.
    load_byte(6'd0, 8'h00);
    load_byte(6'd1, 8'hFF);
    load_byte(6'd2, 8'h80);
    load_byte(6'd3, 8'h01);
    load_byte(6'd4, 8'hAA);
    load_byte(6'd5, 8'h55);
    load_byte(6'd6, 8'h7F);
    load_byte(6'd7, 8'hFE);
    load_byte(6'd63, 8'hC3);
    refresh_frame();
    refresh_frame();

    // A length of zero behaves as one column, scrolling by one every frame.
    configure(8'd0, 8'd1);
    refresh_frame();
    refresh_frame();

    // A length above the store depth, with page flips every 50 frames.
    configure(8'hFF, 8'd50);
    refresh_frame();
    refresh_frame();
    refresh_frame();

    // Smooth scrolling over the whole store walks the offset out to 7; then the length
    // shrinks under it and the reads wrap at the new length.
    configure(8'd64, 8'd1);
    repeat (7) refresh_frame();
    configure(8'd5, 8'd255);
    refresh_frame();
    refresh_frame();

    // The speed drops below the running frame count.
    settle();
    write_reg(CFG_SCROLL_SPEED, 8'd2);
    refresh_frame();
    refresh_frame();
    settle();
    write_reg(CFG_SCROLL_SPEED, 8'd49);
    refresh_frame();

    // Random phases: new settings each time, idle gaps of none, 64 and 29 in a hundred.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: len_pick = 8'd1;
        1: len_pick = 8'd64;
        2: len_pick = 8'd127;
        3: len_pick = 8'd0;
        default: len_pick = 8'($urandom_range(1, 64));
      endcase
      len_pick[7] = 1'($urandom_range(1));
      case ($urandom_range(5))
        0: speed_pick = 8'd0;
        1: speed_pick = 8'd1;
        2: speed_pick = 8'd49;
        3: speed_pick = 8'd50;
        4: speed_pick = 8'($urandom_range(2, 8));
        default: speed_pick = 8'($urandom_range(255));
      endcase
      configure(len_pick, speed_pick);
      case (p % 3)
        0: gap_pct = 0;
        1: gap_pct = 64;
        default: gap_pct = 29;
      endcase
      for (int n = 0; n < 6; n++) begin
        if ($urandom_range(15) == 0) settle();
        if ($urandom_range(99) < 40) begin
          load_byte(6'($urandom_range(63)), 8'($urandom_range(255)));
        end else begin
          refresh_frame();
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("led_matrix_scroll_refresh verification clean");
    end else begin
      $display("led_matrix_scroll_refresh verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lmsr_pkg.sv
rtl/lmsr_front.sv
rtl/lmsr_queue.sv
rtl/lmsr_back.sv
rtl/led_matrix_scroll_refresh.sv
sim/lmsr_frame_monitor.sv
sim/tb_top.sv
